### rtl/rdct_pkg.sv
package rdct_pkg;

    localparam int DEF_MAX_POINTS  = 64;
    localparam int DEF_SAMPLE_BITS = 32;
    localparam int QUEUE_DEPTH     = 4;

    localparam int IO_BITS        = 32;
    localparam int LG_BITS        = 3;
    localparam int MAX_LOG2       = 6;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIRECTION = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOG2_SIZE = 2'd1;

    localparam int W_BITS = 19;
    localparam int W_FRAC = 14;
    localparam logic [W_BITS-1:0] SQRT2_W = 19'd23170;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic               last;
        logic               dir;
        logic [LG_BITS-1:0] lg;
    } rdct_tag_t;

    localparam int TAG_BITS = $bits(rdct_tag_t);

    typedef logic [63:0][W_BITS-1:0] rdct_wtab_t;

    // Unsigned shift-and-subtract quotient, evaluated while building the table.
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned dv);
        longint unsigned qt;
        longint unsigned rm;
        int              b;
        qt = '0;
        rm = '0;
        for (b = 63; b >= 0; b--)
        begin
            rm = {rm[62:0], num[b]};
            qt = qt << 1;
            if (rm >= dv)
            begin
                rm = rm - dv;
                qt = qt | 64'd1;
            end
        end
        return qt;
    endfunction

    // Half-secant weights round(2^14 / (2cos(q*pi/128))), cosine from a Q30 series.
    function automatic rdct_wtab_t build_weights();
        rdct_wtab_t        t;
        longint unsigned   a;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   d;
        longint unsigned   c;
        longint            sum;
        logic              use_sin;
        int                q;
        int                j;
        t = '0;
        for (q = 1; q < 64; q++)
        begin
            use_sin = (q > 32);
            a = use_sin ? longint'(64 - q) : longint'(q);
            x = (a * PI_Q30 + 64'd64) >> 7;
            x2 = (x * x + (64'd1 << 29)) >> 30;
            term = use_sin ? x : (64'd1 << 30);
            sum = longint'(term);
            for (j = 1; j <= 10; j++)
            begin
                d = use_sin ? longint'((2 * j) * (2 * j + 1))
                            : longint'((2 * j - 1) * (2 * j));
                term = udiv64((term * x2 + (64'd1 << 29)) >> 30, d);
                if ((j & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            c = longint'(sum);
            t[q] = W_BITS'(udiv64((64'd1 << 43) + (c >> 1), c));
        end
        return t;
    endfunction

    localparam rdct_wtab_t W_TABLE = build_weights();

endpackage

### rtl/rdct_ram.sv
module rdct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr0,
    output logic [WIDTH-1:0]         rd_data0,
    input  logic [$clog2(DEPTH)-1:0] rd_addr1,
    output logic [WIDTH-1:0]         rd_data1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data0 <= mem[rd_addr0];
        rd_data1 <= mem[rd_addr1];
    end

endmodule

### rtl/rdct_fifo.sv
module rdct_fifo #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/rdct_front.sv
module rdct_front #(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rdct_pkg::IO_BITS-1:0]        s_axis_tdata,   // [31:0] sample
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rdct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rdct_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic                                q_valid,
    input  logic                                q_ready,
    output logic [SAMPLE_BITS+$clog2(MAX_POINTS)+rdct_pkg::TAG_BITS-1:0] q_data
);

    import rdct_pkg::*;

    localparam int AW       = $clog2(MAX_POINTS);
    localparam int TOP_RAW  = $clog2(MAX_POINTS + 1) - 1;
    localparam int TOP_LOG2 = (TOP_RAW > MAX_LOG2) ? MAX_LOG2 : TOP_RAW;
    localparam int SB       = SAMPLE_BITS;

    logic               dir_reg, dir_next;
    logic [LG_BITS-1:0] size_reg, size_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic [LG_BITS-1:0] lg_eff;
    logic [AW-1:0]      last_idx;
    logic [SB-1:0]      sample_sat;
    logic               accept;
    rdct_tag_t          tag;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = q_ready;
    assign q_valid       = s_axis_tvalid;
    assign accept        = s_axis_tvalid && q_ready;

    assign lg_eff   = (size_reg > LG_BITS'(TOP_LOG2)) ? LG_BITS'(TOP_LOG2) : size_reg;
    assign last_idx = AW'((7'd1 << lg_eff) - 7'd1);

    generate
        if (SB < IO_BITS)
        begin : g_sat_in
            logic [IO_BITS-SB:0] hi;
            assign hi = s_axis_tdata[IO_BITS-1:SB-1];
            assign sample_sat = ((&hi) || !(|hi)) ? s_axis_tdata[SB-1:0]
                : {s_axis_tdata[IO_BITS-1], {(SB-1){~s_axis_tdata[IO_BITS-1]}}};
        end
        else if (SB == IO_BITS)
        begin : g_pass_in
            assign sample_sat = s_axis_tdata;
        end
        else
        begin : g_ext_in
            assign sample_sat = {{(SB-IO_BITS){s_axis_tdata[IO_BITS-1]}}, s_axis_tdata};
        end
    endgenerate

    always_comb
    begin
        tag.last = (cnt_reg == last_idx);
        tag.dir  = dir_reg;
        tag.lg   = lg_eff;
    end

    assign q_data = {tag, cnt_reg, sample_sat};

    always_comb
    begin
        dir_next  = dir_reg;
        size_next = size_reg;
        cnt_next  = cnt_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DIRECTION:
                begin
                    dir_next = cfg_data[0];
                    cnt_next = '0;
                end
                CFG_LOG2_SIZE:
                begin
                    size_next = cfg_data[LG_BITS-1:0];
                    cnt_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            cnt_next = tag.last ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= 1'b0;
            size_reg <= 3'd3;
            cnt_reg  <= '0;
        end
        else
        begin
            dir_reg  <= dir_next;
            size_reg <= size_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

### rtl/rdct_back.sv
module rdct_back #(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [SAMPLE_BITS+$clog2(MAX_POINTS)+rdct_pkg::TAG_BITS-1:0] q_data,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [rdct_pkg::IO_BITS-1:0] m_axis_tdata,   // [31:0] value
    output logic                         m_axis_tlast    // final_res
);

    import rdct_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int SB  = SAMPLE_BITS;
    localparam int PB  = SB + 1;
    localparam int PWB = SB + W_BITS + 2;
    localparam int QB  = SB + 2;
    localparam int RB  = SB + 3;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_PRE   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_POST  = 3'd4;
    localparam logic [2:0] S_ORD   = 3'd5;
    localparam logic [2:0] S_OCAP  = 3'd6;
    localparam logic [2:0] S_OHOLD = 3'd7;

    localparam logic [1:0] PRE_X   = 2'd0;
    localparam logic [1:0] PRE_ADD = 2'd1;
    localparam logic [1:0] PRE_SUB = 2'd2;

    localparam logic [1:0] POST_NONE  = 2'd0;
    localparam logic [1:0] POST_HALVE = 2'd1;
    localparam logic [1:0] POST_ADD   = 2'd2;
    localparam logic [1:0] POST_RSUB  = 2'd3;

    typedef struct packed {
        logic [1:0] pre;
        logic       use_mul;
        logic       sh15;
        logic [1:0] post;
    } op_t;

    logic [2:0]         state_reg, state_next;
    logic               dir_reg, dir_next;
    logic [LG_BITS-1:0] lg_reg, lg_next;
    logic [LG_BITS-1:0] lvl_reg, lvl_next;
    logic               up_reg, up_next;
    logic               src_reg, src_next;
    logic [AW-1:0]      k_reg, k_next;
    op_t                op_reg;
    logic [W_BITS-1:0]  w_reg;
    logic signed [PB-1:0]  p_reg;
    logic signed [SB-1:0]  y_reg;
    logic signed [PWB-1:0] prod_reg;
    logic [IO_BITS-1:0] out_data_reg;
    logic               out_last_reg;

    logic [SB-1:0]      ld_sample;
    logic [AW-1:0]      ld_idx;
    rdct_tag_t          ld_tag;
    logic [AW-1:0]      last_k;

    op_t                dec_op;
    logic [6:0]         dec_x, dec_y;
    logic [5:0]         dec_q;
    logic               dec_sqrt2;

    logic [AW-1:0]      rd_addr0, rd_addr1;
    logic [SB-1:0]      a_rd0, a_rd1, b_rd0, b_rd1;
    logic signed [SB-1:0] src_x, src_y;
    logic               a_we, b_we;
    logic [AW-1:0]      a_waddr;
    logic [SB-1:0]      a_wdata;

    logic signed [PB-1:0]  pre_val;
    logic signed [PWB-1:0] prod_rnd, prod_sh;
    logic signed [SB-1:0]  mul_sat;
    logic signed [QB-1:0]  q_val;
    logic signed [RB-1:0]  qe, ye, post_val;
    logic signed [SB-1:0]  res;
    logic [IO_BITS-1:0]    out_val;

    assign ld_sample = q_data[SB-1:0];
    assign ld_idx    = q_data[SB +: AW];
    assign ld_tag    = rdct_tag_t'(q_data[SB+AW +: TAG_BITS]);
    assign last_k    = AW'((7'd1 << lg_reg) - 7'd1);

    // Element decode: which words feed output word k of the current pass.
    always_comb
    begin
        logic [6:0] kk, m, h, base, j, i;
        kk = 7'(k_reg);
        m  = 7'd1 << lvl_reg;
        h  = m >> 1;
        base = kk & ~(m - 7'd1);
        j  = kk & (m - 7'd1);
        i  = '0;
        dec_op    = '{pre: PRE_X, use_mul: 1'b0, sh15: 1'b0, post: POST_NONE};
        dec_x     = kk;
        dec_y     = kk;
        dec_q     = '0;
        dec_sqrt2 = 1'b0;
        if (!dir_reg)
        begin
            if (!up_reg)
            begin
                if (j < h)
                begin
                    dec_x = base + j;
                    dec_y = base + m - 7'd1 - j;
                    dec_op.pre  = PRE_ADD;
                    dec_op.post = POST_HALVE;
                end
                else
                begin
                    i = j - h;
                    dec_x = base + i;
                    dec_y = base + m - 7'd1 - i;
                    dec_op.pre = PRE_SUB;
                    if (lvl_reg == 3'd1)
                        dec_op.post = POST_HALVE;
                    else
                    begin
                        dec_op.use_mul = 1'b1;
                        dec_op.sh15    = 1'b1;
                        dec_q = 6'((((i << 1) | 7'd1)) << (3'd6 - lvl_reg));
                    end
                end
            end
            else
            begin
                i = j >> 1;
                if (!j[0])
                    dec_x = base + i;
                else
                begin
                    dec_x = base + h + i;
                    dec_y = base + h + i + 7'd1;
                    if (i == 7'd0)
                    begin
                        dec_op.use_mul = 1'b1;
                        dec_sqrt2      = 1'b1;
                        dec_op.post    = POST_ADD;
                    end
                    else if (i < h - 7'd1)
                        dec_op.post = POST_ADD;
                end
            end
        end
        else
        begin
            if (lvl_reg == 3'd1)
            begin
                dec_x = base;
                dec_y = base + 7'd1;
                dec_op.pre = (j == 7'd0) ? PRE_ADD : PRE_SUB;
            end
            else if (!up_reg)
            begin
                if (j < h)
                    dec_x = base + (j << 1);
                else
                begin
                    i = j - h;
                    dec_x = base + (i << 1) + 7'd1;
                    dec_y = base + (i << 1) - 7'd1;
                    if (i == 7'd0)
                    begin
                        dec_op.use_mul = 1'b1;
                        dec_sqrt2      = 1'b1;
                    end
                    else
                        dec_op.post = POST_ADD;
                end
            end
            else
            begin
                i = (j < h) ? j : m - 7'd1 - j;
                dec_x = base + h + i;
                dec_y = base + i;
                dec_op.use_mul = 1'b1;
                dec_op.post    = (j < h) ? POST_ADD : POST_RSUB;
                dec_q = 6'((((i << 1) | 7'd1)) << (3'd6 - lvl_reg));
            end
        end
    end

    assign rd_addr0 = (state_reg == S_ISSUE) ? dec_x[AW-1:0] : k_reg;
    assign rd_addr1 = dec_y[AW-1:0];

    assign src_x = src_reg ? b_rd0 : a_rd0;
    assign src_y = src_reg ? b_rd1 : a_rd1;

    // Datapath: pre add/sub, weight product with rounding, post add/subtract/halve.
    always_comb
    begin
        case (op_reg.pre)
            PRE_ADD: pre_val = PB'(src_x) + PB'(src_y);
            PRE_SUB: pre_val = PB'(src_x) - PB'(src_y);
            default: pre_val = PB'(src_x);
        endcase
    end

    assign prod_rnd = prod_reg + (op_reg.sh15 ? (PWB'(1) << W_FRAC) : (PWB'(1) << (W_FRAC - 1)));
    assign prod_sh  = op_reg.sh15 ? (prod_rnd >>> (W_FRAC + 1)) : (prod_rnd >>> W_FRAC);

    always_comb
    begin
        logic [PWB-SB:0] hi;
        hi = prod_sh[PWB-1:SB-1];
        mul_sat = ((&hi) || !(|hi)) ? prod_sh[SB-1:0]
            : {prod_sh[PWB-1], {(SB-1){~prod_sh[PWB-1]}}};
    end

    assign q_val = op_reg.use_mul ? {{2{mul_sat[SB-1]}}, mul_sat} : {p_reg[PB-1], p_reg};
    assign qe    = {q_val[QB-1], q_val};
    assign ye    = {{3{y_reg[SB-1]}}, y_reg};

    always_comb
    begin
        case (op_reg.post)
            POST_HALVE: post_val = (qe + RB'(1)) >>> 1;
            POST_ADD:   post_val = qe + ye;
            POST_RSUB:  post_val = ye - qe;
            default:    post_val = qe;
        endcase
    end

    always_comb
    begin
        logic [RB-SB:0] hi;
        hi = post_val[RB-1:SB-1];
        res = ((&hi) || !(|hi)) ? post_val[SB-1:0]
            : {post_val[RB-1], {(SB-1){~post_val[RB-1]}}};
    end

    generate
        if (SB > IO_BITS)
        begin : g_sat_out
            logic [SB-IO_BITS:0] hi;
            assign hi = src_x[SB-1:IO_BITS-1];
            assign out_val = ((&hi) || !(|hi)) ? src_x[IO_BITS-1:0]
                : {src_x[SB-1], {(IO_BITS-1){~src_x[SB-1]}}};
        end
        else if (SB == IO_BITS)
        begin : g_pass_out
            assign out_val = src_x;
        end
        else
        begin : g_ext_out
            assign out_val = {{(IO_BITS-SB){src_x[SB-1]}}, src_x};
        end
    endgenerate

    assign a_we    = ((state_reg == S_LOAD) && q_valid) || ((state_reg == S_POST) && src_reg);
    assign a_waddr = (state_reg == S_LOAD) ? ld_idx : k_reg;
    assign a_wdata = (state_reg == S_LOAD) ? ld_sample : res;
    assign b_we    = (state_reg == S_POST) && !src_reg;

    rdct_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_POINTS)
    ) u_vector_ram (
        .clk      (clk),
        .wr_en    (a_we),
        .wr_addr  (a_waddr),
        .wr_data  (a_wdata),
        .rd_addr0 (rd_addr0),
        .rd_data0 (a_rd0),
        .rd_addr1 (rd_addr1),
        .rd_data1 (a_rd1)
    );

    rdct_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_POINTS)
    ) u_work_ram (
        .clk      (clk),
        .wr_en    (b_we),
        .wr_addr  (k_reg),
        .wr_data  (res),
        .rd_addr0 (rd_addr0),
        .rd_data0 (b_rd0),
        .rd_addr1 (rd_addr1),
        .rd_data1 (b_rd1)
    );

    assign q_ready       = (state_reg == S_LOAD);
    assign m_axis_tvalid = (state_reg == S_OHOLD);
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        dir_next   = dir_reg;
        lg_next    = lg_reg;
        lvl_next   = lvl_reg;
        up_next    = up_reg;
        src_next   = src_reg;
        k_next     = k_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (q_valid && ld_tag.last)
                begin
                    dir_next = ld_tag.dir;
                    lg_next  = ld_tag.lg;
                    lvl_next = ld_tag.lg;
                    up_next  = 1'b0;
                    src_next = 1'b0;
                    k_next   = '0;
                    state_next = (ld_tag.lg == '0) ? S_ORD : S_ISSUE;
                end
            end
            S_ISSUE: state_next = S_PRE;
            S_PRE:   state_next = S_MUL;
            S_MUL:   state_next = S_POST;
            S_POST:
            begin
                if (k_reg == last_k)
                begin
                    k_next     = '0;
                    src_next   = ~src_reg;
                    state_next = S_ISSUE;
                    // step to the next level: split down to size two, then merge up
                    if (!up_reg)
                    begin
                        if (lvl_reg > 3'd1)
                            lvl_next = lvl_reg - 1'b1;
                        else if (lg_reg == 3'd1)
                            state_next = S_ORD;
                        else
                        begin
                            up_next  = 1'b1;
                            lvl_next = 3'd2;
                        end
                    end
                    else if (lvl_reg == lg_reg)
                        state_next = S_ORD;
                    else
                        lvl_next = lvl_reg + 1'b1;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_ORD:  state_next = S_OCAP;
            S_OCAP: state_next = S_OHOLD;
            S_OHOLD:
            begin
                if (m_axis_tready)
                begin
                    if (out_last_reg)
                        state_next = S_LOAD;
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            dir_reg   <= 1'b0;
            lg_reg    <= '0;
            lvl_reg   <= '0;
            up_reg    <= 1'b0;
            src_reg   <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
            lg_reg    <= lg_next;
            lvl_reg   <= lvl_next;
            up_reg    <= up_next;
            src_reg   <= src_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ISSUE)
        begin
            op_reg <= dec_op;
            w_reg  <= dec_sqrt2 ? SQRT2_W : W_TABLE[dec_q];
        end
        if (state_reg == S_PRE)
        begin
            p_reg <= pre_val;
            y_reg <= src_y;
        end
        if (state_reg == S_MUL)
            prod_reg <= p_reg * $signed({1'b0, w_reg});
        if (state_reg == S_OCAP)
        begin
            out_data_reg <= out_val;
            out_last_reg <= (k_reg == last_k);
        end
    end

endmodule

### rtl/recursive_dct_ii_iii.sv
// Operation: the last sample of a vector of n = 2^lg points starts (2*lg-1) passes of
// n elements on one shared multiply-accumulate unit, then the results leave one by
// one; lg = 0 skips the passes. Loading takes one sample a cycle while the queue has
// room; the back end takes a new vector only after the last result of the previous
// one has left, while a 4-entry queue keeps taking samples.
// Reset: asynchronous, active low; forward direction, 8 points, empty load count.
module recursive_dct_ii_iii #(
    parameter int MAX_POINTS  = rdct_pkg::DEF_MAX_POINTS,
    parameter int SAMPLE_BITS = rdct_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rdct_pkg::IO_BITS-1:0]        s_axis_tdata,   // [31:0] sample
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rdct_pkg::IO_BITS-1:0]        m_axis_tdata,   // [31:0] value
    output logic                                m_axis_tlast,   // final_res
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rdct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rdct_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    import rdct_pkg::*;

    localparam int QW = SAMPLE_BITS + $clog2(MAX_POINTS) + TAG_BITS;

    logic          push_valid, push_ready;
    logic [QW-1:0] push_data;
    logic          pop_valid, pop_ready;
    logic [QW-1:0] pop_data;

    rdct_front #(
        .MAX_POINTS  (MAX_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_valid       (push_valid),
        .q_ready       (push_ready),
        .q_data        (push_data)
    );

    rdct_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rdct_back #(
        .MAX_POINTS  (MAX_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (pop_valid),
        .q_ready       (pop_ready),
        .q_data        (pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### tb/tb_recursive_dct_ii_iii.sv
class dct_scoreboard;
    bit             dir;
    bit [2:0]       lg_reg;
    int             load_cnt;
    longint         mem[128];
    longint unsigned wt[7][32];
    logic [31:0]    exp_value[$];
    bit             exp_last[$];
    int             errors;

    function new();
        int l;
        int i;
        dir = 0;
        lg_reg = 3;
        load_cnt = 0;
        errors = 0;
        for (l = 1; l <= 6; l++)
        begin
            for (i = 0; i < (1 << (l - 1)); i++)
            begin
                wt[l][i] = half_secant(((2 * i) + 1) << (6 - l));
            end
        end
    endfunction

    // Q30 cosine of q*pi/128 by an eleven-term series, then round(2^14 / (2cos)).
    function longint unsigned half_secant(int q);
        bit              by_sin;
        longint unsigned a;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned d;
        longint          acc;
        int              j;
        by_sin = q > 32;
        a = by_sin ? 64 - q : q;
        x = (a * rdct_pkg::PI_Q30 + 64) >> 7;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        term = by_sin ? x : (64'd1 << 30);
        acc = term;
        for (j = 1; j <= 10; j++)
        begin
            d = by_sin ? (2 * j) * (2 * j + 1) : (2 * j - 1) * (2 * j);
            term = ((term * x2 + (64'd1 << 29)) >> 30) / d;
            if (j % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return ((64'd1 << 43) + longint'(acc) / 2) / longint'(acc);
    endfunction

    function longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function longint halve(longint s);
        return (s + 1) >>> 1;
    endfunction

    function longint wmul(longint a, longint unsigned w, int sh);
        logic signed [127:0] p;
        p = $signed({{64{a[63]}}, a}) * $signed({64'd0, w});
        p = p + (128'sd1 <<< (sh - 1));
        p = p >>> sh;
        return p[63:0];
    endfunction

    function void xform(int vb, int l, int sb, bit inv);
        int     m;
        int     h;
        int     i;
        longint a;
        longint b;
        longint r;
        if (l == 0)
            return;
        if (l == 1)
        begin
            a = mem[vb];
            b = mem[vb + 1];
            mem[vb] = sat32(inv ? a + b : halve(a + b));
            mem[vb + 1] = sat32(inv ? a - b : halve(a - b));
            return;
        end
        m = 1 << l;
        h = m / 2;
        if (!inv)
        begin
            for (i = 0; i < h; i++)
            begin
                a = mem[vb + i];
                b = mem[vb + m - 1 - i];
                mem[sb + i] = sat32(halve(a + b));
                mem[sb + h + i] = sat32(wmul(a - b, wt[l][i], rdct_pkg::W_FRAC + 1));
            end
            xform(sb, l - 1, vb, 0);
            xform(sb + h, l - 1, vb + h, 0);
            mem[sb + h] = sat32(wmul(mem[sb + h], rdct_pkg::SQRT2_W, rdct_pkg::W_FRAC));
            for (i = 0; i + 1 < h; i++)
                mem[sb + h + i] = sat32(mem[sb + h + i] + mem[sb + h + i + 1]);
            for (i = 0; i < h; i++)
            begin
                mem[vb + 2 * i] = mem[sb + i];
                mem[vb + 2 * i + 1] = mem[sb + h + i];
            end
        end
        else
        begin
            for (i = 0; i < h; i++)
            begin
                mem[sb + i] = mem[vb + 2 * i];
                mem[sb + h + i] = mem[vb + 2 * i + 1];
            end
            for (i = h - 1; i >= 1; i--)
                mem[sb + h + i] = sat32(mem[sb + h + i] + mem[sb + h + i - 1]);
            mem[sb + h] = sat32(wmul(mem[sb + h], rdct_pkg::SQRT2_W, rdct_pkg::W_FRAC));
            xform(sb, l - 1, vb, 1);
            xform(sb + h, l - 1, vb + h, 1);
            for (i = 0; i < h; i++)
            begin
                r = sat32(wmul(mem[sb + h + i], wt[l][i], rdct_pkg::W_FRAC));
                mem[vb + i] = sat32(mem[sb + i] + r);
                mem[vb + m - 1 - i] = sat32(mem[sb + i] - r);
            end
        end
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
        if (idx == rdct_pkg::CFG_DIRECTION)
        begin
            dir = data[0];
            load_cnt = 0;
        end
        else if (idx == rdct_pkg::CFG_LOG2_SIZE)
        begin
            lg_reg = data[2:0];
            load_cnt = 0;
        end
    endfunction

    function void note_sample(logic [31:0] x);
        int l;
        int n;
        int k;
        l = (lg_reg > rdct_pkg::MAX_LOG2) ? rdct_pkg::MAX_LOG2 : lg_reg;
        n = 1 << l;
        if (load_cnt >= n)
            load_cnt = 0;
        mem[load_cnt] = longint'($signed(x));
        load_cnt++;
        if (load_cnt < n)
            return;
        xform(0, l, 64, dir);
        for (k = 0; k < n; k++)
        begin
            exp_value.push_back(mem[k][31:0]);
            exp_last.push_back(k == n - 1);
        end
        load_cnt = 0;
    endfunction

    function void check_value(logic [31:0] v, logic last);
        logic [31:0] ev;
        bit          el;
        if (exp_value.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected item: value %h last %b", v, last);
            return;
        end
        ev = exp_value.pop_front();
        el = exp_last.pop_front();
        if (v !== ev || last !== el)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected value %h last %b, got value %h last %b",
                         ev, el, v, last);
        end
    endfunction

    function int pending();
        return exp_value.size();
    endfunction
endclass

module tb_recursive_dct_ii_iii;
    import rdct_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IO_BITS-1:0]        s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [IO_BITS-1:0]        m_axis_tdata;
    logic                      m_axis_tlast;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    dct_scoreboard sb;
    bit            no_idle;
    bit            stall_req;
    int            sent;
    int            i;
    int            v;
    int            nv;
    bit            d;
    logic [2:0]    l;

    recursive_dct_ii_iii dut (.*);

    initial clk = 0;
    always #5 clk = ~clk;

    initial
    begin
        #15_000_000;
        $display("status: fail");
        $finish;
    end

    function int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [31:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom;
        if (r < 8)
            return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        return (r == 8) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    // Record handshakes on the falling edge ahead of the rising edge that takes them.
    always @(negedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_sample(s_axis_tdata);
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_value(m_axis_tdata, m_axis_tlast);
    end

    task automatic send_sample(logic [31:0] x);
        int  g;
        bit  ok;
        g = pick_gap();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= x;
        forever
        begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
            if (ok)
                break;
        end
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        bit ok;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        forever
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
            if (ok)
                break;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic setup(bit dir, logic [2:0] lg);
        drain();
        write_reg(CFG_DIRECTION, {7'($urandom_range(0, 127)), dir});
        write_reg(CFG_LOG2_SIZE, {5'($urandom), lg});
    endtask

    initial
    begin
        int g;
        m_axis_tready = 1'b0;
        wait (stall_req === 1'b0);
        @(posedge clk);
        forever
        begin
            if (stall_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge clk);
                stall_req = 0;
            end
            g = pick_gap();
            if (g > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_idle = 0;
        stall_req = 0;
        sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: forward, 8 points, extreme samples.
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0001);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0000_1000);
        setup(1, 3'd1);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        setup(0, 3'd0);
        send_sample(32'h8000_0000);
        send_sample(32'h1234_5678);
        // Partial vector, then two ignored indices, then a discard by a real write.
        setup(0, 3'd2);
        send_sample(32'h0001_0000);
        send_sample(32'hFFF0_0000);
        drain();
        write_reg(2'd2, 8'hFF);
        write_reg(2'd3, 8'h00);
        send_sample(32'h0000_3000);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        drain();
        write_reg(CFG_DIRECTION, 8'h01);
        send_sample(32'h0000_0400);
        send_sample(32'hFFFF_F000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);

        // Oversized length acts as the largest size.
        setup(1, 3'd7);
        for (i = 0; i < 64; i++)
            send_sample(pick_sample());

        // Hold off the output while the input keeps being driven.
        setup(0, 3'd3);
        stall_req = 1;
        for (i = 0; i < 16; i++)
            send_sample(pick_sample());

        while (sent < 170)
        begin
            d = $urandom_range(0, 1);
            l = ($urandom_range(0, 19) == 0) ? 3'd6 : 3'($urandom_range(0, 3));
            no_idle = $urandom_range(0, 3) == 0;
            setup(d, l);
            nv = $urandom_range(1, 3);
            for (v = 0; v < nv * (1 << l) && sent < 170; v++)
                send_sample(pick_sample());
        end
        no_idle = 0;
        drain();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
